>>> rtl/woe_pkg.sv
`default_nettype none
package woe_pkg;
    // Result status codes.
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOT_READY = 3'd1;
    localparam logic [2:0] ST_FAILSAFE  = 3'd2;
    localparam logic [2:0] ST_FIRST     = 3'd3;
    localparam logic [2:0] ST_FAULT     = 3'd4;

    // Configuration register indexes.
    localparam logic REG_FS_ENABLE  = 1'b0;
    localparam logic REG_FAIL_LIMIT = 1'b1;

    // Scale factors of speed and acceleration, and milliseconds to microseconds.
    localparam logic [22:0] SPEED_SCALE = 23'd7131163;
    localparam logic [20:0] ACCEL_SCALE = 21'd2000000;
    localparam logic [9:0]  MS_TO_US    = 10'd1000;

    // Commands from controller to datapath.
    typedef struct packed {
        logic load;        // capture the input word
        logic time_step;   // form intervals and shift time history
        logic spd_start;   // start speed division for current wheel
        logic acc_start;   // start acceleration division for current wheel
        logic spd_save;    // store speed quotient
        logic acc_save;    // store acceleration quotient
        logic commit_ok;   // update totals and previous speed for current wheel
        logic save_prev;   // store speed as previous speed (second sample)
    } t_cmd;

    // Status from datapath to controller.
    typedef struct packed {
        logic div_done;
    } t_sts;
endpackage
`default_nettype wire

>>> rtl/woe_div.sv
`default_nettype none
// Iterative restoring divider: 86-bit magnitude by 64-bit divisor,
// one quotient bit a cycle, result saturated to signed 32 bits.
module woe_div
    import woe_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_start,
    input  wire         i_neg,
    input  wire  [85:0] i_mag,
    input  wire  [63:0] i_div,
    output logic        o_done,
    output logic [31:0] o_quot
);
    logic [85:0] r_num;
    logic [63:0] r_rem;
    logic [63:0] r_div;
    logic [6:0]  r_cnt;
    logic        r_busy, r_neg, r_ovf, r_zero, r_dz;
    logic [64:0] n_trial;
    logic [65:0] n_sub;

    // One shift and trial subtract per cycle.
    always_comb begin
        n_trial = {r_rem, r_num[85]};
        n_sub   = {1'b0, n_trial} - {2'b00, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_num  <= i_mag;
                r_rem  <= '0;
                r_div  <= i_div;
                r_cnt  <= 7'd86;
                r_neg  <= i_neg;
                r_ovf  <= 1'b0;
                r_zero <= (i_mag == '0);
                r_dz   <= (i_div == '0);
            end else if (r_busy) begin
                if (r_zero || r_dz) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end else begin
                    r_num <= {r_num[84:0], ~n_sub[65]};
                    // The remainder stays below the divisor, so 64 bits hold it.
                    r_rem <= n_sub[65] ? n_trial[63:0] : n_sub[63:0];
                    // Quotient bits above bit 31 mark overflow.
                    if (!n_sub[65] && r_cnt > 7'd32) r_ovf <= 1'b1;
                    r_cnt <= r_cnt - 7'd1;
                    if (r_cnt == 7'd1) begin
                        r_busy <= 1'b0;
                        o_done <= 1'b1;
                    end
                end
            end
        end
    end

    // Saturate and apply sign.
    always_comb begin
        if (r_zero)
            o_quot = '0;
        else if (r_dz || r_ovf)
            o_quot = r_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        else if (r_neg)
            o_quot = r_num[31] ? 32'h8000_0000 : (~r_num[31:0] + 32'd1);
        else
            o_quot = r_num[31] ? 32'h7FFF_FFFF : r_num[31:0];
    end
endmodule
`default_nettype wire

>>> rtl/woe_datapath.sv
`default_nettype none
module woe_datapath
    import woe_pkg::*;
#(
    parameter int WHEELS = 4,
    localparam int WW = (WHEELS > 1) ? $clog2(WHEELS) : 1
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire  t_cmd        i_cmd,
    output t_sts              o_sts,
    input  wire  [WW-1:0]     i_wheel,
    input  wire  [16*WHEELS-1:0] i_enc,
    input  wire  [31:0]       i_msec,
    input  wire  [9:0]        i_usec,
    input  wire  [63:0]       i_host,
    output logic [31:0]       o_total,
    output logic [31:0]       o_speed,
    output logic [31:0]       o_accel
);
    logic [15:0] r_cur   [WHEELS];
    logic [15:0] r_prev  [WHEELS];
    logic [15:0] r_delta [WHEELS];
    logic [31:0] r_spd   [WHEELS];
    logic [31:0] r_pspd  [WHEELS];
    logic [31:0] r_acc   [WHEELS];
    logic [31:0] r_tot   [WHEELS];
    logic [31:0] r_msec;
    logic [9:0]  r_usec;
    logic [63:0] r_host, r_phost, r_lapse, r_tdiff;
    logic [63:0] r_mcu0, r_mcu1;
    logic [63:0] n_mcu;
    logic        d_start, d_neg, d_done;
    logic [85:0] d_mag;
    logic [63:0] d_div;
    logic [31:0] d_q;
    logic [15:0] w_d;
    logic [15:0] w_absd;
    logic [32:0] w_sd, w_abssd;

    assign n_mcu = {32'd0, r_msec} * {54'd0, MS_TO_US} + {54'd0, r_usec};
    assign w_d   = r_cur[i_wheel] - r_prev[i_wheel];
    assign w_absd = w_d[15] ? (16'd0 - w_d) : w_d;
    assign w_sd  = {r_spd[i_wheel][31], r_spd[i_wheel]}
                 - {r_pspd[i_wheel][31], r_pspd[i_wheel]};
    assign w_abssd = w_sd[32] ? (33'd0 - w_sd) : w_sd;

    // Operand selection for the shared divider.
    always_comb begin
        d_start = i_cmd.spd_start | i_cmd.acc_start;
        if (i_cmd.acc_start) begin
            d_neg = w_sd[32];
            d_mag = 86'({53'd0, w_abssd} * {65'd0, ACCEL_SCALE});
            d_div = r_tdiff;
        end else begin
            d_neg = w_d[15];
            d_mag = 86'({70'd0, w_absd} * {63'd0, SPEED_SCALE});
            d_div = r_lapse;
        end
    end

    woe_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(d_start), .i_neg(d_neg),
        .i_mag(d_mag), .i_div(d_div), .o_done(d_done), .o_quot(d_q)
    );
    assign o_sts.div_done = d_done;

    // Sample capture, history and per-wheel state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WHEELS; i++) r_tot[i] <= '0;
        end else begin
            if (i_cmd.load) begin
                for (int i = 0; i < WHEELS; i++) r_cur[i] <= i_enc[16*i +: 16];
                r_msec <= i_msec;
                r_usec <= i_usec;
                r_host <= i_host;
            end
            if (i_cmd.time_step) begin
                r_lapse <= r_host - r_phost;
                r_tdiff <= n_mcu - r_mcu0;
                r_mcu0  <= r_mcu1;
                r_mcu1  <= n_mcu;
                r_phost <= r_host;
            end
            if (i_cmd.spd_save) begin
                r_spd[i_wheel]   <= d_q;
                r_delta[i_wheel] <= w_d;
                r_prev[i_wheel]  <= r_cur[i_wheel];
            end
            if (i_cmd.acc_save) r_acc[i_wheel] <= d_q;
            // The speed quotient arrives in the same cycle as its save.
            if (i_cmd.save_prev) r_pspd[i_wheel] <= d_q;
            if (i_cmd.commit_ok) begin
                r_tot[i_wheel]  <= r_tot[i_wheel] + {{16{r_delta[i_wheel][15]}},
                                                     r_delta[i_wheel]};
                r_pspd[i_wheel] <= r_spd[i_wheel];
            end
        end
    end

    // The total shown already includes the delta of the current sample.
    assign o_total = r_tot[i_wheel] + {{16{r_delta[i_wheel][15]}}, r_delta[i_wheel]};
    assign o_speed = r_spd[i_wheel];
    assign o_accel = r_acc[i_wheel];
endmodule
`default_nettype wire

>>> rtl/woe_ctrl.sv
`default_nettype none
module woe_ctrl
    import woe_pkg::*;
#(
    parameter int WHEELS = 4,
    localparam int WW = (WHEELS > 1) ? $clog2(WHEELS) : 1
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_valid,
    output logic         o_ready,
    input  wire  [3:0]   i_sstat,
    input  wire          i_fs_en,
    input  wire  [7:0]   i_limit,
    output t_cmd         o_cmd,
    input  wire  t_sts   i_sts,
    output logic [WW-1:0] o_wheel,
    output logic         o_ovalid,
    input  wire          i_oready,
    output logic [2:0]   o_status,
    output logic [3:0]   o_fault,
    output logic         o_ok,
    output logic         o_last
);
    localparam logic [2:0] S_IDLE = 3'd0, S_TIME = 3'd1, S_SPD = 3'd2,
                           S_SPDW = 3'd3, S_ACC = 3'd4, S_ACCW = 3'd5,
                           S_OUT = 3'd6;
    localparam logic [WW-1:0] LASTW = WW'(WHEELS - 1);

    logic [2:0]    r_state;
    logic [WW-1:0] r_wheel;
    logic [7:0]    r_bad;
    logic          r_latch;
    logic [1:0]    r_good;
    logic          n_out_free;
    logic [7:0]    n_bad;

    assign n_out_free = !o_ovalid || i_oready;
    assign o_ready = (r_state == S_IDLE) && n_out_free;
    assign o_wheel = r_wheel;
    assign n_bad = (r_bad == 8'hFF) ? r_bad : r_bad + 8'd1;

    // Commands decoded from the state.
    always_comb begin
        o_cmd = '0;
        o_cmd.load      = i_valid && o_ready;
        o_cmd.time_step = (r_state == S_TIME);
        o_cmd.spd_start = (r_state == S_SPD);
        o_cmd.spd_save  = (r_state == S_SPDW) && i_sts.div_done;
        o_cmd.acc_start = (r_state == S_ACC);
        o_cmd.acc_save  = (r_state == S_ACCW) && i_sts.div_done;
        o_cmd.save_prev = (r_state == S_SPDW) && i_sts.div_done && (r_good == 2'd2);
        o_cmd.commit_ok = (r_state == S_OUT) && n_out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_wheel  <= '0;
            r_bad    <= '0;
            r_latch  <= 1'b0;
            r_good   <= '0;
            o_ovalid <= 1'b0;
            o_status <= ST_OK;
            o_fault  <= '0;
            o_ok     <= 1'b0;
            o_last   <= 1'b0;
        end else begin
            if (o_ovalid && i_oready) o_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid && n_out_free) begin
                        o_fault <= '0;
                        o_ok    <= 1'b0;
                        o_last  <= 1'b1;
                        if (i_fs_en && r_latch) begin
                            o_ovalid <= 1'b1;
                            o_status <= ST_FAILSAFE;
                        end else if (i_sstat != 4'd0) begin
                            r_bad    <= n_bad;
                            o_ovalid <= 1'b1;
                            if (n_bad < i_limit) begin
                                o_status <= ST_FAULT;
                                o_fault  <= i_sstat;
                            end else begin
                                r_latch  <= 1'b1;
                                o_status <= ST_FAILSAFE;
                            end
                        end else begin
                            r_bad   <= '0;
                            if (r_good != 2'd3) r_good <= r_good + 2'd1;
                            r_wheel <= '0;
                            r_state <= S_TIME;
                        end
                    end
                end
                S_TIME: r_state <= S_SPD;
                S_SPD:  r_state <= S_SPDW;
                S_SPDW: begin
                    if (i_sts.div_done) begin
                        if (r_good == 2'd3) r_state <= S_ACC;
                        else if (r_wheel == LASTW) begin
                            r_state  <= S_IDLE;
                            r_wheel  <= '0;
                            o_ovalid <= 1'b1;
                            o_status <= (r_good == 2'd1) ? ST_FIRST : ST_NOT_READY;
                        end else begin
                            r_wheel <= r_wheel + WW'(1);
                            r_state <= S_SPD;
                        end
                    end
                end
                S_ACC:  r_state <= S_ACCW;
                S_ACCW: if (i_sts.div_done) r_state <= S_OUT;
                S_OUT: begin
                    if (n_out_free) begin
                        o_ovalid <= 1'b1;
                        o_status <= ST_OK;
                        o_ok     <= 1'b1;
                        o_last   <= (r_wheel == LASTW);
                        if (r_wheel == LASTW) r_state <= S_IDLE;
                        else begin
                            r_wheel <= r_wheel + WW'(1);
                            r_state <= S_SPD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Controller checks.
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> r_state == S_IDLE) else $error("ready outside idle");
    a_bad_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TIME) |-> r_bad == 8'd0) else $error("bad count kept");
    a_good_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ovalid && o_ok) |-> r_good == 2'd3) else $error("early ok result");
endmodule
`default_nettype wire

>>> rtl/wheel_odometry_speed_estimator.sv
// Wheel odometry speed estimator.
// Input words arrive on s_axis (tvalid/tready/tdata/tuser); tuser holds the
// sensor status, tdata holds the wheel counts, msec, usec and host time.
// Results leave on m_axis; tuser holds status, fault code and wheel index,
// tdata holds total, speed and acceleration, tlast marks the last word.
// Configuration: i_cfg_valid/o_cfg_ready with index and data; register 0 is
// failsafe enable, register 1 the fail limit. Write only while idle.
// A bad or blocked sample gives its word in the cycle after accept.
// A good sample runs WHEELS speed divisions and, once the history is full,
// WHEELS acceleration divisions on one shared bit-serial divider; a
// division whose numerator or divisor is zero ends without iterating.
// One sample is in flight at a time; a new word is taken once the output
// register is free. Reset clears the counters, latch, totals and outputs.
// A stalled receiver holds the result word and stops the sequence.
`default_nettype none
module wheel_odometry_speed_estimator
    import woe_pkg::*;
#(
    parameter int WHEELS = 4,
    localparam int WW = (WHEELS > 1) ? $clog2(WHEELS) : 1,
    localparam int DW = ((16*WHEELS + 106 + 7) / 8) * 8
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           s_axis_tvalid,
    output logic          s_axis_tready,
    // enc_wheel0..N-1, stamp_msec, stamp_usec, host_time_us
    input  wire  [DW-1:0] s_axis_tdata,
    // sensor_status
    input  wire  [3:0]    s_axis_tuser,
    output logic          m_axis_tvalid,
    input  wire           m_axis_tready,
    // encoder_total, speed, acceleration
    output logic [95:0]   m_axis_tdata,
    // status, fault_code, wheel_index
    output logic [8:0]    m_axis_tuser,
    output logic          m_axis_tlast,
    input  wire           i_cfg_valid,
    output logic          o_cfg_ready,
    input  wire           i_cfg_index,
    input  wire  [7:0]    i_cfg_data
);
    localparam int EW = 16*WHEELS;
    logic          r_fs_en;
    logic [7:0]    r_limit;
    t_cmd          w_cmd;
    t_sts          w_sts;
    logic [WW-1:0] w_wheel, r_owheel;
    logic [2:0]    w_status;
    logic [3:0]    w_fault;
    logic          w_ok;
    logic [31:0]   w_tot, w_spd, w_acc;
    logic [95:0]   r_odata;

    // Configuration registers.
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fs_en <= 1'b1;
            r_limit <= 8'd10;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_FS_ENABLE:  r_fs_en <= i_cfg_data[0];
                REG_FAIL_LIMIT: r_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    woe_ctrl #(.WHEELS(WHEELS)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(s_axis_tvalid),
        .o_ready(s_axis_tready), .i_sstat(s_axis_tuser), .i_fs_en(r_fs_en),
        .i_limit(r_limit), .o_cmd(w_cmd), .i_sts(w_sts), .o_wheel(w_wheel),
        .o_ovalid(m_axis_tvalid), .i_oready(m_axis_tready), .o_status(w_status),
        .o_fault(w_fault), .o_ok(w_ok), .o_last(m_axis_tlast)
    );

    woe_datapath #(.WHEELS(WHEELS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .o_sts(w_sts),
        .i_wheel(w_wheel), .i_enc(s_axis_tdata[EW-1:0]),
        .i_msec(s_axis_tdata[EW +: 32]), .i_usec(s_axis_tdata[EW+32 +: 10]),
        .i_host(s_axis_tdata[EW+42 +: 64]), .o_total(w_tot), .o_speed(w_spd),
        .o_accel(w_acc)
    );

    // Output payload captured with the ok word.
    always_ff @(posedge i_clk) begin
        if (w_cmd.commit_ok) begin
            r_odata  <= {w_acc, w_spd, w_tot};
            r_owheel <= w_wheel;
        end
    end

    assign m_axis_tdata = w_ok ? r_odata : '0;
    assign m_axis_tuser = {w_ok ? 2'(r_owheel) : 2'd0, w_fault, w_status};
endmodule
`default_nettype wire

>>> test/wheel_odometry_speed_estimator_test.sv
`default_nettype none
module wheel_odometry_speed_estimator_test
    import woe_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WHEELS = 4;
    localparam int DW = ((16*WHEELS + 106 + 7) / 8) * 8;
    localparam logic [63:0] SPD_K = 64'd7131163;
    localparam logic [63:0] ACC_K = 64'd2000000;

    // One sensor sample as the block sees it.
    typedef struct {
        logic [3:0]  status;
        logic [15:0] enc [WHEELS];
        logic [31:0] msec;
        logic [9:0]  usec;
        logic [63:0] host;
    } t_sample;

    // One result word.
    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  fault;
        logic [1:0]  wheel;
        logic [31:0] total;
        logic [31:0] speed;
        logic [31:0] accel;
        logic        last;
    } t_odo_word;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [DW-1:0] s_axis_tdata = '0;
    logic [3:0] s_axis_tuser = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [95:0] m_axis_tdata;
    logic [8:0] m_axis_tuser;
    logic m_axis_tlast;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic i_cfg_index = 1'b0;
    logic [7:0] i_cfg_data = '0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    wheel_odometry_speed_estimator #(.WHEELS(WHEELS)) u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // Predictor state.
    logic        fs_enable;
    logic [7:0]  fs_limit;
    logic [7:0]  bad_run;
    logic        latched;
    logic [1:0]  good_count;
    logic [15:0] last_enc [WHEELS];
    logic [63:0] last_host;
    logic [63:0] mcu_hist [2];
    logic [31:0] enc_total [WHEELS];
    logic [31:0] last_speed [WHEELS];

    t_odo_word pending_words [$];
    int errors = 0;
    bit sink_idle_off = 1'b0;
    bit sink_hold = 1'b0;

    task automatic report(input string what);
        errors++;
        $display("MISMATCH: %s", what);
    endtask

    // Truncating signed division of a magnitude, saturated to 32 bits.
    function automatic logic [31:0] sat_quot(input bit neg, input logic [63:0] mag,
                                             input logic [63:0] div);
        logic [63:0] q;
        if (mag == 0) return '0;
        if (div == 0) return neg ? 32'h8000_0000 : 32'h7fff_ffff;
        q = mag / div;
        if (neg) return (q >= 64'h8000_0000) ? 32'h8000_0000 : 32'(-q);
        return (q > 64'h7fff_ffff) ? 32'h7fff_ffff : q[31:0];
    endfunction

    function automatic t_odo_word status_word(input logic [2:0] st, input logic [3:0] f);
        t_odo_word w;
        w = '0;
        w.status = st;
        w.fault = f;
        w.last = 1'b1;
        return w;
    endfunction

    task automatic odometry_predict(input t_sample s);
        logic [63:0] mcu_now, lapse, tdiff, mag;
        logic [31:0] spd [WHEELS];
        logic signed [15:0] delta [WHEELS];
        logic signed [63:0] sd;
        t_odo_word w;
        if (fs_enable && latched) begin
            pending_words.push_back(status_word(ST_FAILSAFE, 4'd0));
            return;
        end
        if (s.status != 0) begin
            if (bad_run != 8'hff) bad_run++;
            if (bad_run < fs_limit) begin
                pending_words.push_back(status_word(ST_FAULT, s.status));
            end else begin
                latched = 1'b1;
                pending_words.push_back(status_word(ST_FAILSAFE, 4'd0));
            end
            return;
        end
        bad_run = '0;
        if (good_count != 2'd3) good_count++;
        mcu_now = 64'(s.msec) * 64'd1000 + 64'(s.usec);
        lapse = s.host - last_host;
        tdiff = mcu_now - mcu_hist[0];
        for (int i = 0; i < WHEELS; i++) begin
            delta[i] = s.enc[i] - last_enc[i];
            last_enc[i] = s.enc[i];
            mag = (delta[i] < 0) ? 64'(-32'(delta[i])) : 64'(delta[i]);
            spd[i] = sat_quot(delta[i] < 0, mag * SPD_K, lapse);
        end
        mcu_hist[0] = mcu_hist[1];
        mcu_hist[1] = mcu_now;
        last_host = s.host;
        if (good_count < 2) begin
            pending_words.push_back(status_word(ST_FIRST, 4'd0));
            return;
        end
        if (good_count < 3) begin
            for (int i = 0; i < WHEELS; i++) last_speed[i] = spd[i];
            pending_words.push_back(status_word(ST_NOT_READY, 4'd0));
            return;
        end
        for (int i = 0; i < WHEELS; i++) begin
            sd = 64'(signed'(spd[i])) - 64'(signed'(last_speed[i]));
            mag = (sd < 0) ? -sd : sd;
            enc_total[i] = enc_total[i] + 32'(delta[i]);
            w = '0;
            w.status = ST_OK;
            w.wheel = 2'(i);
            w.total = enc_total[i];
            w.speed = spd[i];
            w.accel = sat_quot(sd < 0, mag * ACC_K, tdiff);
            w.last = (i == WHEELS - 1);
            pending_words.push_back(w);
            last_speed[i] = spd[i];
        end
    endtask

    // Result checker and receiver stalls.
    always @(posedge i_clk) begin
        t_odo_word got, want;
        if (m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tuser[2:0], m_axis_tuser[6:3], m_axis_tuser[8:7],
                   m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[95:64],
                   m_axis_tlast};
            if (pending_words.size() == 0) begin
                report("result word with nothing expected");
            end else begin
                want = pending_words.pop_front();
                if (got.status != want.status)
                    report($sformatf("status %0d want %0d", got.status, want.status));
                if (got.fault != want.fault)
                    report($sformatf("fault %0d want %0d", got.fault, want.fault));
                if (got.wheel != want.wheel)
                    report($sformatf("wheel %0d want %0d", got.wheel, want.wheel));
                if (got.total != want.total)
                    report($sformatf("total %h want %h", got.total, want.total));
                if (got.speed != want.speed)
                    report($sformatf("speed %h want %h", got.speed, want.speed));
                if (got.accel != want.accel)
                    report($sformatf("accel %h want %h", got.accel, want.accel));
                if (got.last != want.last)
                    report($sformatf("last %0d want %0d", got.last, want.last));
            end
        end
    end

    initial begin : sink
        int n;
        @(posedge i_rst_n);
        forever begin
            if (sink_hold) begin
                m_axis_tready <= 1'b0;
                @(posedge i_clk);
            end else if (!sink_idle_off && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 11);
                m_axis_tready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // Long receiver hold-off, counted here.
    initial begin : long_hold
        @(posedge i_rst_n);
        repeat (3000) @(posedge i_clk);
        sink_hold = 1'b1;
        repeat (2500) @(posedge i_clk);
        sink_hold = 1'b0;
    end

    task automatic cfg_write(input logic idx, input logic [7:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == REG_FS_ENABLE) fs_enable = value[0];
        else fs_limit = value;
        @(posedge i_clk);
    endtask

    task automatic drain;
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (1000) @(posedge i_clk);
    endtask

    task automatic send_sample(input t_sample s, input bit gaps);
        logic [DW-1:0] d;
        if (gaps && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        d = '0;
        for (int i = 0; i < WHEELS; i++) d[16*i +: 16] = s.enc[i];
        d[16*WHEELS +: 32] = s.msec;
        d[16*WHEELS+32 +: 10] = s.usec;
        d[16*WHEELS+42 +: 64] = s.host;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= d;
        s_axis_tuser <= s.status;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        odometry_predict(s);
    endtask

    // Running time base for well-formed samples.
    logic [63:0] host_clk;
    logic [63:0] mcu_clk;

    function automatic t_sample make_good(input int step_us, input int enc_span);
        t_sample s;
        s.status = 4'd0;
        host_clk += 64'(step_us);
        mcu_clk += 64'(step_us) + 64'($urandom_range(0, 40));
        for (int i = 0; i < WHEELS; i++)
            s.enc[i] = last_enc[i] + 16'($urandom_range(0, 2*enc_span) - enc_span);
        s.msec = 32'(mcu_clk / 1000);
        s.usec = 10'(mcu_clk % 1000);
        s.host = host_clk;
        return s;
    endfunction

    function automatic t_sample make_noise();
        t_sample s;
        s.status = 4'($urandom_range(0, 15));
        for (int i = 0; i < WHEELS; i++) s.enc[i] = 16'($urandom);
        s.msec = $urandom;
        s.usec = 10'($urandom_range(0, 999));
        s.host = {$urandom, $urandom};
        return s;
    endfunction

    // Directed stimulus table; the expected status and fault are typed in where they are obvious.
    typedef struct {
        t_sample smp;
        bit      typed;
        logic [2:0] want_status;
        logic [3:0] want_fault;
    } t_dir_row;

    function automatic t_sample mk(input logic [3:0] st, input logic [15:0] e,
                                   input logic [31:0] ms, input logic [9:0] us,
                                   input logic [63:0] h);
        t_sample s;
        s.status = st;
        for (int i = 0; i < WHEELS; i++) s.enc[i] = e ^ 16'(i * 16'h1111);
        s.msec = ms;
        s.usec = us;
        s.host = h;
        return s;
    endfunction

    initial begin : stimulus
        t_dir_row rows [$];
        t_sample s;
        for (int i = 0; i < WHEELS; i++) begin
            last_enc[i] = '0; enc_total[i] = '0; last_speed[i] = '0;
        end
        fs_enable = 1'b1; fs_limit = 8'd10; bad_run = '0; latched = 1'b0;
        good_count = '0; last_host = '0; mcu_hist[0] = '0; mcu_hist[1] = '0;
        host_clk = '0; mcu_clk = '0;

        rows.push_back('{mk(4'd15, 16'h0000, 0, 0, 0), 1, ST_FAULT, 4'd15});
        rows.push_back('{mk(4'd1, 16'hffff, 0, 0, 0), 1, ST_FAULT, 4'd1});
        rows.push_back('{mk(4'd0, 16'h0000, 0, 0, 64'd100), 1, ST_FIRST, 4'd0});
        rows.push_back('{mk(4'd0, 16'h7fff, 0, 999, 64'd100), 1, ST_NOT_READY, 4'd0});
        // Equal host times give a zero interval: speeds saturate.
        rows.push_back('{mk(4'd0, 16'h8000, 0, 999, 64'd100), 0, 0, 0});
        rows.push_back('{mk(4'd0, 16'h8000, 32'hffff_ffff, 999, 64'hffff_ffff_ffff_ffff),
                         0, 0, 0});
        // Host time wraps around.
        rows.push_back('{mk(4'd0, 16'h0001, 32'd5, 10'd3, 64'd20), 0, 0, 0});
        rows.push_back('{mk(4'd0, 16'h0101, 32'd6, 10'd0, 64'd1020), 0, 0, 0});
        rows.push_back('{mk(4'd0, 16'h0101, 32'd7, 10'd0, 64'd2020), 0, 0, 0});
        for (int k = 0; k < 3; k++)
            rows.push_back('{mk(4'd8, 16'h1234, 0, 0, 0), 1, ST_FAULT, 4'd8});

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[r]) begin
            send_sample(rows[r].smp, 0);
            // Typed rows give a single status word, the newest one queued.
            if (rows[r].typed && (pending_words[$].status != rows[r].want_status
                                  || pending_words[$].fault != rows[r].want_fault))
                report($sformatf("row %0d predictor disagrees with table", r));
        end
        s_axis_tvalid <= 1'b0;
        drain();

        // Fail limit of one, latch, then release it by disabling.
        cfg_write(REG_FAIL_LIMIT, 8'd1);
        send_sample(mk(4'd2, 0, 0, 0, 0), 0);
        send_sample(mk(4'd0, 0, 0, 0, 0), 0);
        s_axis_tvalid <= 1'b0;
        drain();
        cfg_write(REG_FS_ENABLE, 8'd0);
        cfg_write(REG_FAIL_LIMIT, 8'd255);
        for (int k = 0; k < 6; k++) send_sample(make_good(1000, 200), 0);
        s_axis_tvalid <= 1'b0;
        drain();

        // Random phases with different settings.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin cfg_write(REG_FS_ENABLE, 8'd1); cfg_write(REG_FAIL_LIMIT, 8'd3); end
                1: begin cfg_write(REG_FAIL_LIMIT, 8'd255); end
                2: begin cfg_write(REG_FS_ENABLE, 8'd0); cfg_write(REG_FAIL_LIMIT, 8'd1); end
                default: begin
                    cfg_write(REG_FAIL_LIMIT, 8'($urandom_range(1, 255)));
                end
            endcase
            if (ph == 3) sink_idle_off = 1'b1;
            for (int k = 0; k < 75; k++) begin
                case ($urandom_range(0, 9))
                    0: s = make_noise();
                    1: begin
                        s = make_good($urandom_range(0, 3), 32767);
                        s.host = {$urandom, $urandom};
                    end
                    2: s = make_good($urandom_range(1, 100000), 32767);
                    default: s = make_good($urandom_range(200, 5000), 3000);
                endcase
                if (ph == 1 && k >= 60 && k < 66) s.status = 4'd3;
                send_sample(s, ph != 3);
                if (ph == 0 && k == 40) begin
                    // Pause until everything is out.
                    s_axis_tvalid <= 1'b0;
                    while (pending_words.size() != 0) @(posedge i_clk);
                end
            end
            s_axis_tvalid <= 1'b0;
            drain();
        end

        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin : watchdog
        #3000000;
        $display("Test completed with failures");
        $finish;
    end
endmodule
`default_nettype wire
